FILE: rtl/ctc_pkg.sv
// shared types and constants for the c subset token classifier
// result item layout, token class codes and the keyword spelling table
// no dependencies
`default_nettype none

package ctc_pkg;

    localparam int KW_NUM  = 6;
    localparam int KW_COLS = 8;

    localparam logic [2:0] CLS_KEYWORD    = 3'd0;
    localparam logic [2:0] CLS_CONSTANT   = 3'd1;
    localparam logic [2:0] CLS_OPERATOR   = 3'd2;
    localparam logic [2:0] CLS_IDENTIFIER = 3'd3;
    localparam logic [2:0] CLS_INVALID    = 3'd4;

    // char, int, return, if, else, for
    localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd4, 3'd3, 3'd6, 3'd2, 3'd4, 3'd3};

    localparam logic [7:0] KW_TEXT [KW_NUM][KW_COLS] = '{
        '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    typedef struct packed {
        logic       last;
        logic [7:0] opc;
        logic [7:0] len;
        logic [2:0] kwi;
        logic [2:0] cls;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    res1;
        t_result    res0;
    } t_lex_out;

endpackage

`default_nettype wire

FILE: rtl/ctc_lexer.sv
// token state and per-character classification
// produces up to two result items per character; uses ctc_pkg
`default_nettype none

module ctc_lexer #(
    parameter int LENGTH_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_char,
    input  logic              i_eol,
    output ctc_pkg::t_lex_out o_lex
);
    import ctc_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam int CW = (LENGTH_BITS > 8) ? LENGTH_BITS : 8;

    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [KW_NUM-1:0]      r_cand, n_cand;
    logic                   r_digits, n_digits;
    logic                   r_ident, n_ident;

    logic [LENGTH_BITS-1:0] w_app_len;
    logic [KW_NUM-1:0]      w_app_cand;
    logic                   w_app_digits;
    logic                   w_app_ident;
    logic                   w_is_sep, w_is_op, w_is_digit, w_is_alpha;
    logic                   w_have_pend;
    t_result                w_pend_res, w_eol_res, w_op_res;

    function automatic t_result classify(
        input logic [LENGTH_BITS-1:0] len,
        input logic [KW_NUM-1:0]      cand,
        input logic                   digits,
        input logic                   ident
    );
        t_result         res;
        logic            found;
        logic [CW-1:0]   len_ext;
        res     = '0;
        found   = 1'b0;
        len_ext = CW'(len);
        for (int i = 0; i < KW_NUM; i++) begin
            if (!found && cand[i] && len_ext == CW'(KW_LEN[i])) begin
                found   = 1'b1;
                res.kwi = 3'(i);
            end
        end
        if (found) begin
            res.cls = CLS_KEYWORD;
        end else if (digits) begin
            res.cls = CLS_CONSTANT;
        end else if (ident) begin
            res.cls = CLS_IDENTIFIER;
        end else begin
            res.cls = CLS_INVALID;
        end
        res.len = (len_ext > CW'(255)) ? 8'hFF : len_ext[7:0];
        return res;
    endfunction

    always_comb begin
        case (i_char) inside
            " ", ",", ";", "(", ")", "{", "}", "[", "]": w_is_sep = 1'b1;
            default:                                      w_is_sep = 1'b0;
        endcase
        case (i_char) inside
            "+", "-", "*", "/", "%", "<", ">", "=", "!": w_is_op = 1'b1;
            default:                                      w_is_op = 1'b0;
        endcase
        w_is_digit = (i_char inside {["0":"9"]});
        w_is_alpha = (i_char inside {["A":"Z"], ["a":"z"], "_"});
    end

    // state after appending the current character
    always_comb begin
        for (int i = 0; i < KW_NUM; i++) begin
            w_app_cand[i] = r_cand[i] && (CW'(r_len) < CW'(KW_LEN[i])) &&
                            (KW_TEXT[i][r_len[2:0]] == i_char);
        end
        w_app_digits = r_digits && w_is_digit;
        if (r_len == '0) begin
            w_app_ident = w_is_alpha;
        end else begin
            w_app_ident = r_ident && (w_is_alpha || w_is_digit);
        end
        w_app_len = (r_len != LEN_MAX) ? r_len + 1'b1 : r_len;
    end

    always_comb begin
        w_have_pend = (r_len != '0);
        w_pend_res  = classify(r_len, r_cand, r_digits, r_ident);
        w_eol_res   = classify(w_app_len, w_app_cand, w_app_digits, w_app_ident);
        w_eol_res.last = 1'b1;
        w_op_res      = '0;
        w_op_res.cls  = CLS_OPERATOR;
        w_op_res.len  = 8'd1;
        w_op_res.opc  = i_char;
        w_op_res.last = 1'b1;

        o_lex    = '0;
        n_len    = '0;
        n_cand   = '1;
        n_digits = 1'b1;
        n_ident  = 1'b1;
        if (w_is_sep) begin
            o_lex.cnt       = {1'b0, w_have_pend};
            o_lex.res0      = w_pend_res;
            o_lex.res0.last = 1'b1;
        end else if (w_is_op) begin
            if (w_have_pend) begin
                o_lex.cnt  = 2'd2;
                o_lex.res0 = w_pend_res;
                o_lex.res1 = w_op_res;
            end else begin
                o_lex.cnt  = 2'd1;
                o_lex.res0 = w_op_res;
            end
        end else if (i_eol) begin
            o_lex.cnt  = 2'd1;
            o_lex.res0 = w_eol_res;
        end else begin
            n_len    = w_app_len;
            n_cand   = w_app_cand;
            n_digits = w_app_digits;
            n_ident  = w_app_ident;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_cand   <= '1;
            r_digits <= 1'b1;
            r_ident  <= 1'b1;
        end else if (i_step) begin
            r_len    <= n_len;
            r_cand   <= n_cand;
            r_digits <= n_digits;
            r_ident  <= n_ident;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ctc_outbuf.sv
// two-slot result register feeding the output stream
// holds the one or two result items of a character; uses ctc_pkg
`default_nettype none

module ctc_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ctc_pkg::t_lex_out i_lex,
    input  logic              i_ready,
    output logic              o_valid,
    output ctc_pkg::t_result  o_res,
    output logic              o_can_take
);
    import ctc_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_result    r_slot0, r_slot1;
    logic       w_pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_res      = r_slot0;
    assign w_pop      = o_valid && i_ready;
    assign o_can_take = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);

    always_comb begin
        if (i_load) begin
            n_cnt = i_lex.cnt;
        end else if (w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot0 <= i_lex.res0;
            r_slot1 <= i_lex.res1;
        end else if (w_pop) begin
            r_slot0 <= r_slot1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/c_subset_token_classifier_top.sv
// top level of the c subset token classifier
// input register, ctc_lexer and ctc_outbuf; uses ctc_pkg
//
// channel  dir  tdata fields (lsb up)                          tlast
// s        in   char_code[7:0]                                  end_of_line
// m        out  token_class[2:0] keyword_index[5:3]             last_of_run
//               token_length[13:6] operator_char[21:14] pad
//
// one character per cycle when m does not stall; a character that closes a pending token and
// is itself an operator yields two items, and the input holds until the slots can take more
// items, as m sends one item at a time; characters pass the input register, then the
// result slots. reset clears the token state and both registers at once, no clearing pass.
// a stall on m fills the result slots, then the input register, then drops s tready.
`default_nettype none

module c_subset_token_classifier_top #(
    parameter int LENGTH_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // char_code
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // token_class, keyword_index, token_length, operator_char
    output logic        o_m_tlast
);
    import ctc_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eol;
    logic       w_adv;
    logic       w_load;
    logic       w_can_take;
    t_lex_out   w_lex;
    t_result    w_res;

    assign w_adv      = r_in_valid && (w_can_take || (w_lex.cnt == 2'd0));
    assign w_load     = w_adv && (w_lex.cnt != 2'd0);
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_eol  <= i_s_tlast;
        end
    end

    ctc_lexer #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_lexer (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (w_adv),
        .i_char (r_in_char),
        .i_eol  (r_in_eol),
        .o_lex  (w_lex)
    );

    ctc_outbuf u_outbuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_lex     (w_lex),
        .i_ready   (i_m_tready),
        .o_valid   (o_m_tvalid),
        .o_res     (w_res),
        .o_can_take(w_can_take)
    );

    assign o_m_tdata = {2'b00, w_res.opc, w_res.len, w_res.kwi, w_res.cls};
    assign o_m_tlast = w_res.last;

    a_load_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_can_take)
        else $error("result slots overrun");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> o_m_tvalid)
        else $error("second item of a character missing");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] <= CLS_INVALID))
        else $error("token class out of range");

    a_operator_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[2:0] == CLS_OPERATOR) |->
            (o_m_tdata[13:6] == 8'd1 && o_m_tdata[21:14] != 8'd0 && o_m_tlast))
        else $error("malformed operator item");

endmodule

`default_nettype wire
